>>> rtl/lgf_pkg.sv
// shared types, constants and helpers of the linear gradient fill block
`timescale 1ns / 1ps

package lgf_pkg;

    localparam int CANVAS_SIDE   = 16384;
    localparam int FRACTION_BITS = 14;

    localparam int PIX_W  = 14;                 // canvas coordinate
    localparam int LEN_W  = 15;                 // region extent
    localparam int AXIS_W = 16;                 // q1.14 axis component
    localparam int COL_W  = 32;                 // packed rgba
    localparam int CH_W   = 8;
    localparam int NUM_CH = COL_W / CH_W;
    localparam int EXT_W  = 18;                 // room for start + extent
    localparam int PROD_W = PIX_W + AXIS_W + 1; // coordinate times axis
    localparam int PROJ_W = PROD_W + 1;         // projection
    localparam int DIFF_W = PROJ_W + 1;         // projection minus low bound
    localparam int SPAN_W = PROD_W;
    localparam int Q_BITS = 16;                 // q0.16 position
    localparam int U_W    = Q_BITS + 1;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [SPAN_W-1:0] UNIT_SPAN = SPAN_W'(1) << FRACTION_BITS;
    localparam logic [U_W-1:0]    U_ONE     = U_W'(1) << Q_BITS;

    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_TOP    = 3'd1,
        REG_WIDTH  = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_COS    = 3'd4,
        REG_SIN    = 3'd5,
        REG_START  = 3'd6,
        REG_END    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_col;
        logic [PIX_W-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } t_color;

    typedef struct packed {
        logic [PIX_W-1:0]         region_left;
        logic [PIX_W-1:0]         region_top;
        logic [LEN_W-1:0]         region_width;
        logic [LEN_W-1:0]         region_height;
        logic signed [AXIS_W-1:0] axis_cos;
        logic signed [AXIS_W-1:0] axis_sin;
        logic [COL_W-1:0]         start_color;
        logic [COL_W-1:0]         end_color;
    } t_cfg;

    // gradient bounds derived from the region corners
    typedef struct packed {
        logic signed [PROJ_W-1:0] lo;
        logic [SPAN_W-1:0]        span;
    } t_bounds;

    // divider result with its saturation flags
    typedef struct packed {
        logic              zero;
        logic              full;
        logic [Q_BITS-1:0] q;
    } t_quot;

    function automatic logic signed [PROD_W-1:0] mul_axis(
        input logic [PIX_W-1:0]         x,
        input logic signed [AXIS_W-1:0] a
    );
        logic signed [PROD_W-1:0] xe;
        logic signed [PROD_W-1:0] ae;
        xe = PROD_W'($signed({1'b0, x}));
        ae = PROD_W'(a);
        return xe * ae;
    endfunction

endpackage

>>> rtl/linear_gradient_fill.sv
// top level of the linear gradient fill pipeline
//
//   channel   direction  handshake                 payload
//   pixel     in         i_in_valid / o_in_stall   i_pixel  (pixel_col, pixel_row)
//   color     out        o_out_valid / i_out_stall o_color  (red, green, blue, alpha)
//   config    in         apb psel/penable/pwrite   paddr[4:2] register, pwdata
//
// one item per cycle unless the output stalls
// 22 register stages: 4 projection, 16 divider (one quotient bit each), 2 blend
// region bounds are recomputed from the registers after a write
// reset clears all valid bits and loads the register defaults
// a stalled output freezes the whole pipeline; o_in_stall is high only then
`timescale 1ns / 1ps

module linear_gradient_fill (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lgf_pkg::t_pixel               i_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lgf_pkg::t_color               o_color,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lgf_pkg::ADDR_W-1:0]    paddr,
    input  logic [lgf_pkg::DATA_W-1:0]    pwdata,
    output logic [lgf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import lgf_pkg::*;

    t_cfg                     cfg;
    t_bounds                  bounds;
    logic                     en;
    logic                     proj_valid, div_valid;
    logic signed [DIFF_W-1:0] diff;
    t_quot                    quot;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    lgf_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_bounds (bounds)
    );

    lgf_proj u_proj (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_pixel    (i_pixel),
        .i_axis_cos (cfg.axis_cos),
        .i_axis_sin (cfg.axis_sin),
        .i_lo       (bounds.lo),
        .o_valid    (proj_valid),
        .o_diff     (diff)
    );

    lgf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (proj_valid),
        .i_diff  (diff),
        .i_span  (bounds.span),
        .o_valid (div_valid),
        .o_quot  (quot)
    );

    lgf_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_quot  (quot),
        .i_start (cfg.start_color),
        .i_end   (cfg.end_color),
        .o_valid (o_out_valid),
        .o_color (o_color)
    );

endmodule

>>> rtl/lgf_cfg.sv
// configuration registers and the region bound pipeline
`timescale 1ns / 1ps

module lgf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lgf_pkg::ADDR_W-1:0]    paddr,
    input  logic [lgf_pkg::DATA_W-1:0]    pwdata,
    output logic [lgf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output lgf_pkg::t_cfg                 o_cfg,
    output lgf_pkg::t_bounds              o_bounds
);
    import lgf_pkg::*;

    localparam t_cfg CFG_RESET = '{
        region_left:   '0,
        region_top:    '0,
        region_width:  LEN_W'(1),
        region_height: LEN_W'(1),
        axis_cos:      AXIS_W'(16384),
        axis_sin:      '0,
        start_color:   COL_W'(32'h0000_00ff),
        end_color:     COL_W'(32'hffff_ffff)
    };

    t_cfg r_cfg;

    logic [PIX_W-1:0] x0, x1, y0, y1;

    logic signed [PROD_W-1:0] r_x0c, r_x1c, r_y0s, r_y1s;
    logic signed [PROD_W-1:0] r_min_x, r_min_y;
    logic [SPAN_W-1:0]        r_dx, r_dy;
    t_bounds                  r_bounds;

    logic signed [PROD_W-1:0] n_min_x, n_min_y, diff_x, diff_y;
    logic [SPAN_W-1:0]        n_dx, n_dy, span_sum;
    t_bounds                  n_bounds;

    // first and last index of one region axis after clipping to the canvas
    function automatic logic [2*PIX_W-1:0] clip_axis(
        input logic [PIX_W-1:0] start,
        input logic [LEN_W-1:0] len
    );
        logic [EXT_W-1:0] s;
        logic [EXT_W-1:0] n;
        logic [EXT_W-1:0] e;
        s = EXT_W'(start);
        if (s > EXT_W'(CANVAS_SIDE - 1)) begin
            s = EXT_W'(CANVAS_SIDE - 1);
        end
        n = EXT_W'(len);
        if (n == '0) begin
            n = EXT_W'(1);
        end
        if (s + n > EXT_W'(CANVAS_SIDE)) begin
            n = EXT_W'(CANVAS_SIDE) - s;
        end
        e = s + n - EXT_W'(1);
        return {s[PIX_W-1:0], e[PIX_W-1:0]};
    endfunction

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_LEFT:   r_cfg.region_left   <= pwdata[PIX_W-1:0];
                REG_TOP:    r_cfg.region_top    <= pwdata[PIX_W-1:0];
                REG_WIDTH:  r_cfg.region_width  <= pwdata[LEN_W-1:0];
                REG_HEIGHT: r_cfg.region_height <= pwdata[LEN_W-1:0];
                REG_COS:    r_cfg.axis_cos      <= $signed(pwdata[AXIS_W-1:0]);
                REG_SIN:    r_cfg.axis_sin      <= $signed(pwdata[AXIS_W-1:0]);
                REG_START:  r_cfg.start_color   <= pwdata[COL_W-1:0];
                REG_END:    r_cfg.end_color     <= pwdata[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_LEFT:   prdata = DATA_W'(r_cfg.region_left);
            REG_TOP:    prdata = DATA_W'(r_cfg.region_top);
            REG_WIDTH:  prdata = DATA_W'(r_cfg.region_width);
            REG_HEIGHT: prdata = DATA_W'(r_cfg.region_height);
            REG_COS:    prdata = {{(DATA_W-AXIS_W){r_cfg.axis_cos[AXIS_W-1]}}, r_cfg.axis_cos};
            REG_SIN:    prdata = {{(DATA_W-AXIS_W){r_cfg.axis_sin[AXIS_W-1]}}, r_cfg.axis_sin};
            REG_START:  prdata = DATA_W'(r_cfg.start_color);
            REG_END:    prdata = DATA_W'(r_cfg.end_color);
            default:    prdata = '0;
        endcase
    end

    assign {x0, x1} = clip_axis(r_cfg.region_left, r_cfg.region_width);
    assign {y0, y1} = clip_axis(r_cfg.region_top, r_cfg.region_height);

    // min and span (max minus min) over the corners, split into a column part and a row part
    always_comb begin
        diff_x   = r_x1c - r_x0c;
        diff_y   = r_y1s - r_y0s;
        n_min_x  = (r_x0c < r_x1c) ? r_x0c : r_x1c;
        n_min_y  = (r_y0s < r_y1s) ? r_y0s : r_y1s;
        n_dx     = diff_x[PROD_W-1] ? SPAN_W'(-diff_x) : SPAN_W'(diff_x);
        n_dy     = diff_y[PROD_W-1] ? SPAN_W'(-diff_y) : SPAN_W'(diff_y);
        span_sum = r_dx + r_dy;
        n_bounds.lo   = PROJ_W'(r_min_x) + PROJ_W'(r_min_y);
        n_bounds.span = (span_sum == '0) ? UNIT_SPAN : span_sum;
    end

    // reset values match the reset register contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0c         <= '0;
            r_x1c         <= '0;
            r_y0s         <= '0;
            r_y1s         <= '0;
            r_min_x       <= '0;
            r_min_y       <= '0;
            r_dx          <= '0;
            r_dy          <= '0;
            r_bounds.lo   <= '0;
            r_bounds.span <= UNIT_SPAN;
        end else begin
            r_x0c    <= mul_axis(x0, r_cfg.axis_cos);
            r_x1c    <= mul_axis(x1, r_cfg.axis_cos);
            r_y0s    <= mul_axis(y0, r_cfg.axis_sin);
            r_y1s    <= mul_axis(y1, r_cfg.axis_sin);
            r_min_x  <= n_min_x;
            r_min_y  <= n_min_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_bounds <= n_bounds;
        end
    end

    assign o_cfg    = r_cfg;
    assign o_bounds = r_bounds;

endmodule

>>> rtl/lgf_proj.sv
// pixel projection onto the gradient axis and offset from the low bound
`timescale 1ns / 1ps

module lgf_proj (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  lgf_pkg::t_pixel                     i_pixel,
    input  logic signed [lgf_pkg::AXIS_W-1:0]   i_axis_cos,
    input  logic signed [lgf_pkg::AXIS_W-1:0]   i_axis_sin,
    input  logic signed [lgf_pkg::PROJ_W-1:0]   i_lo,
    output logic                                o_valid,
    output logic signed [lgf_pkg::DIFF_W-1:0]   o_diff
);
    import lgf_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0]        r_v;
    t_pixel                   r_pix;
    logic signed [PROD_W-1:0] r_pc, r_ps;
    logic signed [PROJ_W-1:0] r_p;
    logic signed [DIFF_W-1:0] r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= i_pixel;
            r_pc  <= mul_axis(r_pix.pixel_col, i_axis_cos);
            r_ps  <= mul_axis(r_pix.pixel_row, i_axis_sin);
            r_p   <= PROJ_W'(r_pc) + PROJ_W'(r_ps);
            r_d   <= DIFF_W'(r_p) - DIFF_W'(i_lo);
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_diff  = r_d;

endmodule

>>> rtl/lgf_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module lgf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [lgf_pkg::DIFF_W-1:0]   i_diff,
    input  logic [lgf_pkg::SPAN_W-1:0]          i_span,
    output logic                                o_valid,
    output lgf_pkg::t_quot                      o_quot
);
    import lgf_pkg::*;

    logic [Q_BITS-1:0]              r_v;
    logic [Q_BITS-1:0]              r_zero;
    logic [Q_BITS-1:0]              r_full;
    logic [Q_BITS-1:0][SPAN_W-1:0]  r_rem;
    logic [Q_BITS-1:0][Q_BITS-1:0]  r_q;

    logic [Q_BITS-1:0]              v_in, zero_in, full_in;
    logic [Q_BITS-1:0][SPAN_W-1:0]  rem_in;
    logic [Q_BITS-1:0][Q_BITS-1:0]  q_in;
    logic [Q_BITS-1:0][SPAN_W-1:0]  n_rem;
    logic [Q_BITS-1:0][Q_BITS-1:0]  n_q;

    always_comb begin
        logic [SPAN_W:0] t;
        logic            ge;
        // first stage takes the offset; out-of-range offsets only set a flag
        v_in[0]    = i_valid;
        zero_in[0] = i_diff[DIFF_W-1] || (i_diff == '0);
        full_in[0] = !i_diff[DIFF_W-1] && (i_diff >= $signed(DIFF_W'(i_span)));
        rem_in[0]  = i_diff[SPAN_W-1:0];
        q_in[0]    = '0;
        for (int k = 1; k < Q_BITS; k++) begin
            v_in[k]    = r_v[k-1];
            zero_in[k] = r_zero[k-1];
            full_in[k] = r_full[k-1];
            rem_in[k]  = r_rem[k-1];
            q_in[k]    = r_q[k-1];
        end
        for (int k = 0; k < Q_BITS; k++) begin
            t        = {rem_in[k], 1'b0};
            ge       = (t >= {1'b0, i_span});
            n_rem[k] = ge ? SPAN_W'(t - {1'b0, i_span}) : t[SPAN_W-1:0];
            n_q[k]   = {q_in[k][Q_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= v_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= zero_in;
            r_full <= full_in;
            r_rem  <= n_rem;
            r_q    <= n_q;
        end
    end

    assign o_valid     = r_v[Q_BITS-1];
    assign o_quot.zero = r_zero[Q_BITS-1];
    assign o_quot.full = r_full[Q_BITS-1];
    assign o_quot.q    = r_q[Q_BITS-1];

endmodule

>>> rtl/lgf_blend.sv
// per-channel blend between start and end colors with rounding
`timescale 1ns / 1ps

module lgf_blend (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  lgf_pkg::t_quot               i_quot,
    input  logic [lgf_pkg::COL_W-1:0]    i_start,
    input  logic [lgf_pkg::COL_W-1:0]    i_end,
    output logic                         o_valid,
    output lgf_pkg::t_color              o_color
);
    import lgf_pkg::*;

    localparam int SD_W = CH_W + 1;
    localparam int PW   = SD_W + U_W + 1;
    localparam logic signed [PW-1:0] ROUND = PW'(1) << (Q_BITS - 1);

    logic                          r_va, r_vb;
    logic signed [PW-1:0]          r_prod [NUM_CH];
    t_color                        r_color;

    logic [U_W-1:0]                u;
    logic signed [PW-1:0]          n_prod [NUM_CH];
    logic [NUM_CH-1:0][CH_W-1:0]   n_ch;

    // channel = s + ((e - s) * u + half) >> 16, which equals the weighted sum
    always_comb begin
        logic signed [PW-1:0] sd;
        logic signed [PW-1:0] ue;
        logic signed [PW-1:0] rnd;
        logic [CH_W-1:0]      s;
        logic [CH_W-1:0]      e;
        if (i_quot.zero) begin
            u = '0;
        end else if (i_quot.full) begin
            u = U_ONE;
        end else begin
            u = {1'b0, i_quot.q};
        end
        ue = PW'($signed({1'b0, u}));
        for (int c = 0; c < NUM_CH; c++) begin
            s         = i_start[COL_W-1-CH_W*c -: CH_W];
            e         = i_end[COL_W-1-CH_W*c -: CH_W];
            sd        = PW'($signed({1'b0, e}) - $signed({1'b0, s}));
            n_prod[c] = sd * ue;
            rnd       = r_prod[c] + ROUND;
            rnd       = rnd >>> Q_BITS;
            n_ch[NUM_CH-1-c] = i_start[COL_W-1-CH_W*c -: CH_W] + rnd[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_color <= t_color'(n_ch);
        end
    end

    assign o_valid = r_vb;
    assign o_color = r_color;

endmodule

>>> rtl/lgf_chk.sv
// port-level checks of the linear gradient fill, bound to the top level
`timescale 1ns / 1ps

module lgf_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  lgf_pkg::t_color               o_color,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lgf_pkg::ADDR_W-1:0]    paddr,
    input  logic [lgf_pkg::DATA_W-1:0]    pwdata,
    input  logic [lgf_pkg::DATA_W-1:0]    prdata
);
    import lgf_pkg::*;

    // no result survives a reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_color))
        else $error("stalled result changed");

    // the input side only waits on a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without an output stall");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[4:2] == REG_START)
        |=> (paddr[4:2] != REG_START) || (prdata == $past(pwdata)))
        else $error("start color read back differs from write");

endmodule

bind linear_gradient_fill lgf_chk u_chk (.*);
